FILE: hdl/sfr_pkg.sv
package sfr_pkg;

  localparam int unsigned FuncW  = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 10;
  localparam int unsigned LenW   = 11;

  localparam logic [ByteW-1:0] CodeEnd    = 8'hC0;
  localparam logic [ByteW-1:0] CodeEsc    = 8'hDB;
  localparam logic [ByteW-1:0] CodeEscEnd = 8'hDC;
  localparam logic [ByteW-1:0] CodeEscEsc = 8'hDD;

  typedef enum logic [FuncW-1:0] {
    FUNC_BYTE    = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_TRANSFER = 2'd1,
    MODE_ESCAPE   = 2'd2,
    MODE_READY    = 2'd3
  } mode_e;

  typedef struct packed {
    logic            frame_ready;
    logic [LenW-1:0] frame_length;
    logic            flow_enable;
    logic            in_escape;
  } status_t;

endpackage

FILE: hdl/sfr_if.sv
interface sfr_req_if
  import sfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [ByteW-1:0]  rx_byte;
  logic [IndexW-1:0] read_index;

  modport source (output valid, func, rx_byte, read_index, input ready);
  modport sink   (input valid, func, rx_byte, read_index, output ready);
endinterface

interface sfr_rsp_if
  import sfr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] read_data;
  logic             frame_ready;
  logic [LenW-1:0]  frame_length;
  logic             flow_enable;
  logic             in_escape;

  modport source (output valid, read_data, frame_ready, frame_length, flow_enable, in_escape,
                  input ready);
  modport sink   (input valid, read_data, frame_ready, frame_length, flow_enable, in_escape,
                  output ready);
endinterface

FILE: hdl/sfr_frame_mem.sv
module sfr_frame_mem
  import sfr_pkg::*;
#(
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [ByteW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [ByteW-1:0] rd_data_o
);

  logic [ByteW-1:0] mem_q [Depth];
  logic [ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/slip_frame_receiver.sv
// SLIP receive deframer. One request is taken per clock cycle unless the output
// stalls, and each request gives one response, through the registered read of
// the frame buffer and then the output register. The buffer is a
// single memory with one write port and one read port; a received data byte
// writes it and a read request reads it, so the two never contend. Responses
// carry the status after the request and read data for reads (zero otherwise,
// and zero for an index at or beyond the buffer depth). The buffer is not
// cleared at reset, so an entry must be written before it is read; there is no
// startup sweep and the block is ready right out of reset. Bytes past the
// buffer depth are dropped, and bytes arriving while a frame is ready are
// discarded until a release request.
module slip_frame_receiver
  import sfr_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfr_req_if.sink    req_i,
  sfr_rsp_if.source  rsp_o
);

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CntW  = $clog2(BUFFER_DEPTH + 1);

  mode_e           mode_q, mode_d;
  logic [CntW-1:0] wpos_q, wpos_d;
  logic            flow_q, flow_d;

  logic             req_fire;
  logic             wr_en;
  logic [ByteW-1:0] wr_data;
  logic             rd_en;
  logic             idx_ok;
  logic [ByteW-1:0] rd_data;
  status_t          status_d;

  logic    s1_valid_q;
  logic    s1_rd_q;
  status_t s1_status_q;
  logic    s1_adv;

  logic             out_valid_q;
  logic [ByteW-1:0] out_data_q;
  status_t          out_status_q;

  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_fire    = req_i.valid && req_i.ready;
  assign idx_ok      = 32'(req_i.read_index) < BUFFER_DEPTH;

  always_comb begin
    logic [ByteW-1:0] b;
    logic             append;
    b       = req_i.rx_byte;
    append  = 1'b0;
    mode_d  = mode_q;
    wpos_d  = wpos_q;
    flow_d  = flow_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    if (req_fire) begin
      unique case (req_i.func)
        FUNC_BYTE: begin
          if (mode_q == MODE_ESCAPE) begin
            if (b == CodeEscEnd) begin
              b = CodeEnd;
            end else if (b == CodeEscEsc) begin
              b = CodeEsc;
            end
            append = 1'b1;
          end else if (mode_q != MODE_READY) begin
            if (b == CodeEsc) begin
              mode_d = MODE_ESCAPE;
            end else if (b == CodeEnd) begin
              if (wpos_q == '0) begin
                mode_d = MODE_IDLE;
              end else begin
                mode_d = MODE_READY;
                flow_d = 1'b0;
              end
            end else begin
              append = 1'b1;
            end
          end
        end
        FUNC_READ: begin
          rd_en = idx_ok;
        end
        FUNC_RELEASE: begin
          if (mode_q == MODE_READY) begin
            wpos_d = '0;
            mode_d = MODE_IDLE;
            flow_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (append) begin
      mode_d = MODE_TRANSFER;
      if (wpos_q < CntW'(BUFFER_DEPTH)) begin
        wr_en  = 1'b1;
        wpos_d = wpos_q + CntW'(1);
      end
    end
    wr_data = b;
    status_d.frame_ready  = (mode_d == MODE_READY);
    status_d.frame_length = LenW'(wpos_d);
    status_d.flow_enable  = flow_d;
    status_d.in_escape    = (mode_d == MODE_ESCAPE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      wpos_q <= '0;
      flow_q <= 1'b1;
    end else begin
      mode_q <= mode_d;
      wpos_q <= wpos_d;
      flow_q <= flow_d;
    end
  end

  sfr_frame_mem #(
    .Depth (BUFFER_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wpos_q[AddrW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (AddrW'(req_i.read_index)),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_rd_q     <= rd_en;
      s1_status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || rsp_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q   <= s1_rd_q ? rd_data : '0;
      out_status_q <= s1_status_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.read_data    = out_data_q;
  assign rsp_o.frame_ready  = out_status_q.frame_ready;
  assign rsp_o.frame_length = out_status_q.frame_length;
  assign rsp_o.flow_enable  = out_status_q.flow_enable;
  assign rsp_o.in_escape    = out_status_q.in_escape;

  a_flow_vs_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.flow_enable == !rsp_o.frame_ready))
    else $error("flow enable disagrees with frame ready");

  a_ready_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_READY) |-> (wpos_q != '0) && !flow_q)
    else $error("ready frame is empty or flow still on");

  a_write_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (wpos_q == $past(wpos_q) + CntW'(1)))
    else $error("buffer write without position advance");

endmodule
